### rtl/core/grouped_free_block_allocator_assert.svh
// Assertion macros for the grouped free-block allocator checker.
// Used by gfba_checker.sv; no other dependencies.
`ifndef GROUPED_FREE_BLOCK_ALLOCATOR_ASSERT_SVH
`define GROUPED_FREE_BLOCK_ALLOCATOR_ASSERT_SVH

// overlapping implication, masked while reset is high
`define GFBA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, masked while reset is high
`define GFBA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also holds across reset
`define GFBA_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/gfba_pkg.sv
// Shared types and codes for the grouped free-block allocator.
// No dependencies.
`default_nettype none

package gfba_pkg;

   localparam int unsigned BLOCK_NUM_W = 8;
   localparam int unsigned STATUS_W    = 2;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVER = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_REDUCE,
      ST_SPILL,
      ST_RELOAD
   } state_type;

endpackage

`default_nettype wire

### rtl/core/gfba_if.sv
// Request and response channel interfaces of the grouped free-block allocator.
// Depends on gfba_pkg for field widths.
`default_nettype none

interface gfba_req_if;
   logic                               valid;
   logic                               ready;
   logic                               kind;
   logic [gfba_pkg::BLOCK_NUM_W-1:0]   block_number;

   modport source (output valid, output kind, output block_number, input ready);
   modport sink   (input valid, input kind, input block_number, output ready);
endinterface

interface gfba_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [gfba_pkg::BLOCK_NUM_W-1:0]   allocated_block;
   logic [gfba_pkg::STATUS_W-1:0]      status;

   modport source (output valid, output allocated_block, output status, input ready);
   modport sink   (input valid, input allocated_block, input status, output ready);
endinterface

`default_nettype wire

### rtl/core/gfba_link_mem.sv
// Link word store: ROWS rows of GROUP_SIZE words, one row per block.
// Per-row valid bits make unwritten rows read as zero. Depends on gfba_pkg.
`default_nettype none

module gfba_link_mem #(
   parameter int unsigned ROWS       = 256,
   parameter int unsigned GROUP_SIZE = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   wr_en,
   input  wire logic [$clog2(ROWS)-1:0]                wr_row,
   input  wire logic [$clog2(GROUP_SIZE)-1:0]          wr_idx,
   input  wire logic [gfba_pkg::BLOCK_NUM_W-1:0]       wr_data,
   input  wire logic [$clog2(ROWS)-1:0]                rd_row,
   input  wire logic [$clog2(GROUP_SIZE)-1:0]          rd_idx,
   output logic      [gfba_pkg::BLOCK_NUM_W-1:0]       rd_data
);

   localparam int unsigned IDX_W   = $clog2(GROUP_SIZE);
   localparam int unsigned DEPTH   = ROWS * GROUP_SIZE;
   localparam int unsigned ADDR_W  = $clog2(DEPTH);

   logic [gfba_pkg::BLOCK_NUM_W-1:0] mem [DEPTH];
   logic [ROWS-1:0]                  row_valid_ff;
   logic [gfba_pkg::BLOCK_NUM_W-1:0] rd_word_ff;
   logic                             rd_hit_ff;
   logic [ADDR_W-1:0]                wr_addr;
   logic [ADDR_W-1:0]                rd_addr;

   assign wr_addr = ADDR_W'(wr_row) * ADDR_W'(GROUP_SIZE) + ADDR_W'(wr_idx);
   assign rd_addr = ADDR_W'(rd_row) * ADDR_W'(GROUP_SIZE) + ADDR_W'(rd_idx);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_word_ff <= mem[rd_addr];
   end

   // a row becomes valid once its last word lands; rows are only written whole
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_hit_ff    <= 1'b0;
      end else begin
         if (wr_en && (wr_idx == IDX_W'(GROUP_SIZE - 1))) begin
            row_valid_ff[wr_row] <= 1'b1;
         end
         rd_hit_ff <= row_valid_ff[rd_row];
      end
   end

   assign rd_data = rd_hit_ff ? rd_word_ff : '0;

endmodule

`default_nettype wire

### rtl/core/grouped_free_block_allocator.sv
// Grouped free-block allocator top level: free-number stack memory and sequencer.
// Depends on gfba_pkg, gfba_if and gfba_link_mem.
//
//   channel   dir   fields                          accepted when
//   req_if    in    kind, block_number              valid && ready
//   rsp_if    out   allocated_block, status         valid && ready
//
// Refused items and plain pushes are answered from idle, a plain pop from POP.
// A spill runs REDUCE then SPILL, and a reload runs POP, REDUCE and RELOAD;
// REDUCE takes the block number modulo LINK_ROWS; one link word moves per cycle.
// Reset is synchronous; link rows read as zero until spilled, so no clearing pass.
// An item is taken only in idle with the response register free or draining.
`default_nettype none

module grouped_free_block_allocator #(
   parameter int unsigned GROUP_SIZE  = 16,
   parameter int unsigned BLOCK_COUNT = 256
) (
   input  wire logic   clock,
   input  wire logic   reset,
   gfba_req_if.sink    req_if,
   gfba_rsp_if.source  rsp_if
);

   localparam int unsigned BN_W      = gfba_pkg::BLOCK_NUM_W;
   localparam int unsigned SP_W      = $clog2(GROUP_SIZE + 1);
   localparam int unsigned IDX_W     = $clog2(GROUP_SIZE);
   localparam int unsigned FT_W      = $clog2(BLOCK_COUNT + 1);
   localparam int unsigned LINK_ROWS = (BLOCK_COUNT > 255) ? 256 : BLOCK_COUNT;
   localparam int unsigned ROW_W     = $clog2(LINK_ROWS);

   gfba_pkg::state_type state_ff, state_in;

   logic [SP_W-1:0]                 sp_ff, sp_in;
   logic [FT_W-1:0]                 ft_ff, ft_in;
   logic [SP_W-1:0]                 cnt_ff, cnt_in;
   logic                            kind_ff, kind_in;
   logic [BN_W-1:0]                 blk_ff, blk_in;
   logic [BN_W-1:0]                 mod_ff, mod_in;
   logic [BN_W-1:0]                 given_ff, given_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [BN_W-1:0]                 rsp_block_ff, rsp_block_in;
   logic [gfba_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   logic [BN_W-1:0]   stack_mem [GROUP_SIZE];
   logic [BN_W-1:0]   st_rdata_ff;
   logic [IDX_W-1:0]  st_raddr;
   logic              st_we;
   logic [IDX_W-1:0]  st_waddr;
   logic [BN_W-1:0]   st_wdata;

   logic              lk_we;
   logic [IDX_W-1:0]  lk_widx;
   logic [BN_W-1:0]   lk_wdata;
   logic [IDX_W-1:0]  lk_ridx;
   logic [BN_W-1:0]   lk_rdata;
   logic [ROW_W-1:0]  row;

   logic              accept;
   logic [SP_W-1:0]   sp_m1;
   logic [SP_W-1:0]   cnt_m1;

   assign accept        = req_if.valid && req_if.ready;
   assign req_if.ready  = (state_ff == gfba_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_if.ready);
   assign sp_m1         = sp_ff - SP_W'(1);
   assign cnt_m1        = cnt_ff - SP_W'(1);
   assign row           = mod_ff[ROW_W-1:0];

   // stack memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (st_we) begin
         stack_mem[st_waddr] <= st_wdata;
      end
      st_rdata_ff <= stack_mem[st_raddr];
   end

   gfba_link_mem #(
      .ROWS       (LINK_ROWS),
      .GROUP_SIZE (GROUP_SIZE)
   ) u_gfba_link_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (lk_we),
      .wr_row  (row),
      .wr_idx  (lk_widx),
      .wr_data (lk_wdata),
      .rd_row  (row),
      .rd_idx  (lk_ridx),
      .rd_data (lk_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      sp_in         = sp_ff;
      ft_in         = ft_ff;
      cnt_in        = cnt_ff;
      kind_in       = kind_ff;
      blk_in        = blk_ff;
      mod_in        = mod_ff;
      given_in      = given_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_block_in  = rsp_block_ff;
      rsp_status_in = rsp_status_ff;
      st_raddr      = '0;
      st_we         = 1'b0;
      st_waddr      = '0;
      st_wdata      = '0;
      lk_we         = 1'b0;
      lk_widx       = cnt_m1[IDX_W-1:0];
      lk_wdata      = st_rdata_ff;
      lk_ridx       = cnt_ff[IDX_W-1:0];

      unique case (state_ff)
         gfba_pkg::ST_IDLE: begin
            if (accept) begin
               kind_in = req_if.kind;
               blk_in  = req_if.block_number;
               mod_in  = req_if.block_number;
               cnt_in  = '0;
               if (req_if.kind == gfba_pkg::KIND_ALLOC) begin
                  if ((ft_ff == '0) || (sp_ff >= SP_W'(GROUP_SIZE))) begin
                     rsp_valid_in  = 1'b1;
                     rsp_block_in  = '0;
                     rsp_status_in = gfba_pkg::STATUS_FULL;
                  end else begin
                     st_raddr = sp_ff[IDX_W-1:0];
                     state_in = gfba_pkg::ST_POP;
                  end
               end else begin
                  if (ft_ff >= FT_W'(BLOCK_COUNT)) begin
                     rsp_valid_in  = 1'b1;
                     rsp_block_in  = '0;
                     rsp_status_in = gfba_pkg::STATUS_OVER;
                  end else if (sp_ff != '0) begin
                     st_we         = 1'b1;
                     st_waddr      = sp_m1[IDX_W-1:0];
                     st_wdata      = req_if.block_number;
                     sp_in         = sp_m1;
                     ft_in         = ft_ff + FT_W'(1);
                     rsp_valid_in  = 1'b1;
                     rsp_block_in  = '0;
                     rsp_status_in = gfba_pkg::STATUS_OK;
                  end else begin
                     state_in = gfba_pkg::ST_REDUCE;
                  end
               end
            end
         end

         gfba_pkg::ST_POP: begin
            if (sp_ff == SP_W'(GROUP_SIZE - 1)) begin
               // last of the group: its link words become the new stack
               given_in = st_rdata_ff;
               mod_in   = st_rdata_ff;
               state_in = gfba_pkg::ST_REDUCE;
            end else begin
               sp_in         = sp_ff + SP_W'(1);
               ft_in         = ft_ff - FT_W'(1);
               rsp_valid_in  = 1'b1;
               rsp_block_in  = st_rdata_ff;
               rsp_status_in = gfba_pkg::STATUS_OK;
               state_in      = gfba_pkg::ST_IDLE;
            end
         end

         gfba_pkg::ST_REDUCE: begin
            // block number modulo LINK_ROWS (BLOCK_COUNT capped at 256) by repeated subtraction
            if ({1'b0, mod_ff} >= 9'(LINK_ROWS)) begin
               mod_in = mod_ff - BN_W'(LINK_ROWS);
            end else begin
               cnt_in   = '0;
               state_in = (kind_ff == gfba_pkg::KIND_FREE) ? gfba_pkg::ST_SPILL
                                                           : gfba_pkg::ST_RELOAD;
            end
         end

         gfba_pkg::ST_SPILL: begin
            // read stack word cnt, write the one read last beat
            st_raddr = cnt_ff[IDX_W-1:0];
            lk_we    = (cnt_ff != '0);
            cnt_in   = cnt_ff + SP_W'(1);
            if (cnt_ff == SP_W'(GROUP_SIZE)) begin
               st_we         = 1'b1;
               st_waddr      = IDX_W'(GROUP_SIZE - 1);
               st_wdata      = blk_ff;
               sp_in         = SP_W'(GROUP_SIZE - 1);
               ft_in         = ft_ff + FT_W'(1);
               rsp_valid_in  = 1'b1;
               rsp_block_in  = '0;
               rsp_status_in = gfba_pkg::STATUS_OK;
               state_in      = gfba_pkg::ST_IDLE;
            end
         end

         gfba_pkg::ST_RELOAD: begin
            st_we    = (cnt_ff != '0);
            st_waddr = cnt_m1[IDX_W-1:0];
            st_wdata = lk_rdata;
            cnt_in   = cnt_ff + SP_W'(1);
            if (cnt_ff == SP_W'(GROUP_SIZE)) begin
               sp_in         = '0;
               ft_in         = ft_ff - FT_W'(1);
               rsp_valid_in  = 1'b1;
               rsp_block_in  = given_ff;
               rsp_status_in = gfba_pkg::STATUS_OK;
               state_in      = gfba_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = gfba_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gfba_pkg::ST_IDLE;
         sp_ff        <= SP_W'(GROUP_SIZE);
         ft_ff        <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         ft_ff        <= ft_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      blk_ff        <= blk_in;
      mod_ff        <= mod_in;
      given_ff      <= given_in;
      rsp_block_ff  <= rsp_block_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.allocated_block = rsp_block_ff;
   assign rsp_if.status          = rsp_status_ff;

endmodule

`default_nettype wire

### rtl/core/gfba_checker.sv
// Port-level checker for the grouped free-block allocator, bound to the top level.
// Depends on gfba_pkg and grouped_free_block_allocator_assert.svh.
`default_nettype none

`include "grouped_free_block_allocator_assert.svh"

module gfba_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic [gfba_pkg::BLOCK_NUM_W-1:0]    rsp_allocated_block,
   input wire logic [gfba_pkg::STATUS_W-1:0]       rsp_status
);

   logic       req_beat;
   logic       rsp_beat;
   logic [1:0] pending_ff;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   // requests taken but not yet answered
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_ff + 2'(req_beat) - 2'(rsp_beat);
      end
   end

   `GFBA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
   `GFBA_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_allocated_block) && $stable(rsp_status), "response changed while stalled")
   `GFBA_ASSERT_IMP(a_rsp_owed, clock, reset, rsp_valid, pending_ff != 2'd0, "response without a request")
   `GFBA_ASSERT_NXT_ALWAYS(a_reset_quiet, clock, reset, !rsp_valid, "response valid after reset")

endmodule

bind grouped_free_block_allocator gfba_checker u_gfba_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_if.valid),
   .req_ready           (req_if.ready),
   .rsp_valid           (rsp_if.valid),
   .rsp_ready           (rsp_if.ready),
   .rsp_allocated_block (rsp_if.allocated_block),
   .rsp_status          (rsp_if.status)
);

`default_nettype wire
